>>> hw/rtl/pmt_pkg.sv
// ============================================================================
// PS/2 mouse packet tracker package
// Shared types and constants for the packet tracker front, queue and back.
// ============================================================================
package pmt_pkg;

    localparam int OUT_POS_W  = 10;
    localparam int LIMIT_W    = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int HALF_W     = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_X_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = 10'd312;
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = 10'd194;
    localparam int                 CURSOR_RESET  = 100;

    localparam logic [7:0] HEAD_SYNC_MASK = 8'h08;
    localparam logic [7:0] HEAD_XSIGN_MASK = 8'h10;
    localparam logic [7:0] HEAD_YSIGN_MASK = 8'h20;
    localparam logic [7:0] HEAD_BTN_MASK  = 8'h07;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       from_aux;
    } t_in;

    typedef struct packed {
        logic [OUT_POS_W-1:0] pos_x;
        logic [OUT_POS_W-1:0] pos_y;
        logic [2:0]           buttons;
        logic                 packet_done;
        logic                 moved;
    } t_out;

    typedef struct packed {
        logic                     done;
        logic                     moved;
        logic [2:0]               buttons;
        logic signed [HALF_W-1:0] half_dx;
        logic signed [HALF_W-1:0] half_dy;
    } t_cmd;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_ADDR_W-1:0] addr;
        logic [LIMIT_W-1:0]    data;
    } t_cfg_wr;

endpackage

>>> hw/rtl/pmt_front.sv
// ============================================================================
// Packet tracker front end
// Accepts controller bytes, assembles three-byte packets and issues one
// command per byte with the halved deltas and button bits.
// ============================================================================
module pmt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmt_pkg::t_in   i_in,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_space,
    output logic           o_push,
    output pmt_pkg::t_cmd  o_cmd
);
    import pmt_pkg::*;

    localparam logic [1:0] PH_HEAD  = 2'd0;
    localparam logic [1:0] PH_XBYTE = 2'd1;
    localparam logic [1:0] PH_YBYTE = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_head, n_head;
    logic [7:0] r_xbyte, n_xbyte;

    logic signed [8:0] dx_raw;
    logic signed [8:0] dx_half;
    logic signed [9:0] dy_src;
    logic signed [9:0] dy_raw;
    logic signed [9:0] dy_half;
    logic              accept;

    assign o_in_ready = i_space;
    assign accept     = i_in_valid && i_space;
    assign o_push     = accept;

    assign dx_raw  = {(r_head & HEAD_XSIGN_MASK) != 8'h00, r_xbyte};
    assign dx_half = (dx_raw + $signed({8'h00, dx_raw[8]})) >>> 1;
    assign dy_src  = {{2{(r_head & HEAD_YSIGN_MASK) != 8'h00}}, i_in.data_byte};
    assign dy_raw  = -dy_src;
    assign dy_half = (dy_raw + $signed({9'h000, dy_raw[9]})) >>> 1;

    always_comb begin
        n_phase       = r_phase;
        n_head        = r_head;
        n_xbyte       = r_xbyte;
        o_cmd.done    = 1'b0;
        o_cmd.moved   = 1'b0;
        o_cmd.buttons = 3'd0;
        o_cmd.half_dx = dx_half;
        o_cmd.half_dy = dy_half[HALF_W-1:0];
        if (i_in.from_aux) begin
            unique case (r_phase)
                PH_XBYTE: begin
                    n_xbyte = i_in.data_byte;
                    n_phase = PH_YBYTE;
                end
                PH_YBYTE: begin
                    n_phase       = PH_HEAD;
                    o_cmd.done    = 1'b1;
                    o_cmd.moved   = (dx_raw != 9'sd0) || (dy_src != 10'sd0);
                    o_cmd.buttons = r_head[2:0] & HEAD_BTN_MASK[2:0];
                end
                default: begin
                    if ((i_in.data_byte & HEAD_SYNC_MASK) != 8'h00) begin
                        n_head  = i_in.data_byte;
                        n_phase = PH_XBYTE;
                    end else begin
                        n_phase = PH_HEAD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_head  <= 8'h00;
            r_xbyte <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_head  <= n_head;
            r_xbyte <= n_xbyte;
        end
    end

endmodule

>>> hw/rtl/pmt_queue.sv
// ============================================================================
// Packet tracker command queue
// Small first-in first-out buffer that decouples the front end from the
// cursor update stage.
// ============================================================================
module pmt_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pmt_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output pmt_pkg::t_cmd  o_cmd
);
    import pmt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/pmt_back.sv
// ============================================================================
// Packet tracker back end
// Holds the limit registers, applies each command to the cursor with
// clamping and presents the result in an output register.
// ============================================================================
module pmt_back #(
    parameter int POS_WIDTH = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pmt_pkg::t_cfg_wr i_cfg,
    input  logic             i_cmd_valid,
    input  pmt_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pmt_pkg::t_out    o_out
);
    import pmt_pkg::*;

    localparam int SW = POS_WIDTH + 2;
    localparam logic [SW-1:0] POS_MAX = {2'b00, {POS_WIDTH{1'b1}}};

    logic [LIMIT_W-1:0]   r_x_limit;
    logic [LIMIT_W-1:0]   r_y_limit;
    logic [POS_WIDTH-1:0] r_cursor_x, n_cursor_x;
    logic [POS_WIDTH-1:0] r_cursor_y, n_cursor_y;
    logic [2:0]           r_buttons, n_buttons;
    logic                 r_out_valid;
    t_out                 r_out;

    function automatic logic [POS_WIDTH-1:0] f_step(
        input logic [POS_WIDTH-1:0]     cur,
        input logic signed [HALF_W-1:0] half,
        input logic [LIMIT_W-1:0]       limit
    );
        logic [SW-1:0] lim;
        logic [SW-1:0] sum;
        logic [SW-1:0] res;
        lim = SW'(limit);
        if (lim > POS_MAX) begin
            lim = POS_MAX;
        end
        sum = {2'b00, cur} + {{(SW-HALF_W){half[HALF_W-1]}}, half};
        if (sum[SW-1]) begin
            res = '0;
        end else if (sum >= lim) begin
            res = lim;
        end else begin
            res = sum;
        end
        return res[POS_WIDTH-1:0];
    endfunction

    assign o_pop       = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_buttons  = r_buttons;
        if (i_cmd.done) begin
            n_buttons = i_cmd.buttons;
        end
        if (i_cmd.moved) begin
            n_cursor_x = f_step(r_cursor_x, i_cmd.half_dx, r_x_limit);
            n_cursor_y = f_step(r_cursor_y, i_cmd.half_dy, r_y_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= X_LIMIT_RESET;
            r_y_limit <= Y_LIMIT_RESET;
        end else if (i_cfg.wr_en) begin
            unique case (i_cfg.addr)
                REG_X_LIMIT: r_x_limit <= i_cfg.data;
                REG_Y_LIMIT: r_y_limit <= i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= POS_WIDTH'(CURSOR_RESET);
            r_cursor_y  <= POS_WIDTH'(CURSOR_RESET);
            r_buttons   <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cursor_x  <= n_cursor_x;
                r_cursor_y  <= n_cursor_y;
                r_buttons   <= n_buttons;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.pos_x       <= OUT_POS_W'(n_cursor_x);
            r_out.pos_y       <= OUT_POS_W'(n_cursor_y);
            r_out.buttons     <= n_buttons;
            r_out.packet_done <= i_cmd.done;
            r_out.moved       <= i_cmd.moved;
        end
    end

endmodule

>>> hw/rtl/ps2_mouse_packet_tracker.sv
// Path: each accepted byte's command is registered in the command queue and
// then in the output register.
// Throughput: one byte per cycle unless a result stalls; then the two-entry
// command queue takes two more bytes before the input stops.
// Reset: synchronous, active low; the limits return to 312 and 194, the
// cursor to (100, 100), the buttons to zero and the packet framing to idle.
// ============================================================================
// PS/2 mouse packet tracker
// Decodes three-byte mouse packets into a clamped cursor position and
// the current button state.
// ============================================================================
module ps2_mouse_packet_tracker #(
    parameter int POS_WIDTH = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pmt_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pmt_pkg::LIMIT_W-1:0]        i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pmt_pkg::t_in                       i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pmt_pkg::t_out                      o_out
);
    import pmt_pkg::*;

    t_cfg_wr cfg;
    t_cmd    push_cmd;
    t_cmd    pop_cmd;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_valid;

    assign cfg.wr_en = i_cfg_wr_en;
    assign cfg.addr  = i_cfg_addr;
    assign cfg.data  = i_cfg_wr_data;

    pmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_space    (!q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    pmt_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (pop_cmd)
    );

    pmt_back #(
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

>>> hw/rtl/pmt_checker.sv
// ============================================================================
// Packet tracker port checker
// Watches the top-level ports for result and back-pressure consistency.
// ============================================================================
module pmt_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_in_ready,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  pmt_pkg::t_out o_out
);
    import pmt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("Result changed while its transaction was stalled.");

    a_moved_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out.moved || o_out.packet_done))
        else $error("Movement reported without a completed packet.");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("Result valid right after reset.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("Input stalled without a pending result.");

endmodule

bind ps2_mouse_packet_tracker pmt_checker u_pmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// PS/2 mouse packet tracker testbench
// Feeds mouse and non-mouse bytes through the valid/ready input and compares
// every report on the output with an in-bench model of the packet framing,
// delta decoding and cursor clamping. The limits are changed between phases.
// The receiver stalls at random and once holds off long enough to back up
// the input.
// ============================================================================
module tb;
    import pmt_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {PH_HEAD, PH_X, PH_Y} t_phase;
    typedef enum int {RX_OPEN, RX_CHOPPY, RX_STARVED} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [LIMIT_W-1:0]    i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out;

    t_phase             phase   = PH_HEAD;
    logic [7:0]         head_q  = '0;
    logic [7:0]         xbyte_q = '0;
    int                 cur_x   = CURSOR_RESET;
    int                 cur_y   = CURSOR_RESET;
    logic [2:0]         btn_q   = '0;
    logic [LIMIT_W-1:0] lim_x   = X_LIMIT_RESET;
    logic [LIMIT_W-1:0] lim_y   = Y_LIMIT_RESET;

    t_out pending_reports[$];

    int mismatches  = 0;
    int n_mouse     = 0;
    int n_ignored   = 0;
    int n_packets   = 0;
    int n_moved     = 0;
    int n_settings  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit pacing      = 1'b1;
    bit hold_off_req = 1'b0;

    ps2_mouse_packet_tracker uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_axis(input int v, input logic [LIMIT_W-1:0] lim);
        int top;
        top = int'(lim);
        if (v < 0) v = 0;
        if (v >= top) v = top;
        return v;
    endfunction

    function automatic t_out track_byte(input t_in item);
        t_out r;
        int   dx;
        int   dy;
        r = '0;
        if (item.from_aux) begin
            case (phase)
                PH_X: begin
                    xbyte_q = item.data_byte;
                    phase = PH_Y;
                end
                PH_Y: begin
                    dx = int'(xbyte_q) - (((head_q & HEAD_XSIGN_MASK) != 0) ? 256 : 0);
                    dy = -(int'(item.data_byte) -
                           (((head_q & HEAD_YSIGN_MASK) != 0) ? 256 : 0));
                    phase = PH_HEAD;
                    r.packet_done = 1'b1;
                    btn_q = 3'(head_q & HEAD_BTN_MASK);
                    if (dx != 0 || dy != 0) begin
                        r.moved = 1'b1;
                        cur_x = clamp_axis(cur_x + dx / 2, lim_x);
                        cur_y = clamp_axis(cur_y + dy / 2, lim_y);
                    end
                end
                default: begin
                    if ((item.data_byte & HEAD_SYNC_MASK) != 0) begin
                        head_q = item.data_byte;
                        phase = PH_X;
                    end else begin
                        phase = PH_HEAD;
                    end
                end
            endcase
        end
        r.pos_x = cur_x[OUT_POS_W-1:0];
        r.pos_y = cur_y[OUT_POS_W-1:0];
        r.buttons = btn_q;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic aux);
        t_in  item;
        t_out r;
        item.data_byte = value;
        item.from_aux = aux;
        i_in <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        r = track_byte(item);
        pending_reports.push_back(r);
        if (aux) n_mouse++;
        else n_ignored++;
        if (r.packet_done) n_packets++;
        if (r.moved) n_moved++;
        if (pacing) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(head, 1'b1);
        send_byte(dx, 1'b1);
        send_byte(dy, 1'b1);
    endtask

    task automatic wait_for_reports();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [LIMIT_W-1:0] x_top,
                                input logic [LIMIT_W-1:0] y_top);
        wait_for_reports();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= REG_X_LIMIT;
        i_cfg_wr_data <= x_top;
        @(posedge i_clk);
        lim_x = x_top;
        i_cfg_addr <= REG_Y_LIMIT;
        i_cfg_wr_data <= y_top;
        @(posedge i_clk);
        lim_y = y_top;
        i_cfg_wr_en <= 1'b0;
        n_settings++;
        @(posedge i_clk);
    endtask

    task automatic test_framing();
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF7, 1'b1);
        send_packet(8'h0F, 8'h00, 8'h00);
        send_byte(8'hC8, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h00, 1'b1);
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'h18, 8'hFF, 8'h01);
    endtask

    task automatic test_limits();
        write_limits('0, '0);
        send_packet(8'h08, 8'h02, 8'h02);
        write_limits('1, '1);
        send_packet(8'h2A, 8'hFF, 8'h00);
        write_limits(10'd50, 10'd60);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h08, 8'h04, 8'hFC);
    endtask

    task automatic test_backpressure();
        wait_for_reports();
        pacing = 1'b0;
        hold_off_req = 1'b1;
        repeat (10) begin
            send_packet(8'($urandom()) | HEAD_SYNC_MASK, 8'($urandom()), 8'($urandom()));
        end
        pacing = 1'b1;
        wait_for_reports();
    endtask

    task automatic test_random_walk(input logic [LIMIT_W-1:0] x_top,
                                    input logic [LIMIT_W-1:0] y_top,
                                    input bit drift, input int packets);
        logic [7:0] head;
        int         pick;
        write_limits(x_top, y_top);
        repeat (packets) begin
            pick = $urandom_range(0, 99);
            head = 8'($urandom()) | HEAD_SYNC_MASK;
            if (drift) head = (head & ~HEAD_XSIGN_MASK) | HEAD_YSIGN_MASK;
            if (pick < 80) begin
                send_byte(head, 1'b1);
                if ($urandom_range(0, 9) == 0) send_byte(8'($urandom()), 1'b0);
                send_byte(8'($urandom()), 1'b1);
                send_byte(8'($urandom()), 1'b1);
            end else if (pick < 90) begin
                send_byte(8'($urandom()), 1'($urandom()));
            end else if (pick < 95) begin
                send_byte(head & ~HEAD_SYNC_MASK, 1'b1);
            end else begin
                send_byte(head, 1'b1);
                send_byte(8'($urandom()), 1'b1);
            end
        end
    endtask

    initial begin
        t_rx_mode rx_mode;
        int       seg_left;
        rx_mode = RX_OPEN;
        seg_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                seg_left = $urandom_range(1, 40);
            end
            seg_left--;
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_CHOPPY: i_out_ready <= 1'($urandom_range(0, 1));
                default:   i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected report: pos_x %0d pos_y %0d", o_out.pos_x, o_out.pos_y);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (o_out.pos_x !== want.pos_x) begin
                    $error("pos_x: expected %0d, actual %0d", want.pos_x, o_out.pos_x);
                    mismatches++;
                end
                if (o_out.pos_y !== want.pos_y) begin
                    $error("pos_y: expected %0d, actual %0d", want.pos_y, o_out.pos_y);
                    mismatches++;
                end
                if (o_out.buttons !== want.buttons) begin
                    $error("buttons: expected %0d, actual %0d", want.buttons, o_out.buttons);
                    mismatches++;
                end
                if (o_out.packet_done !== want.packet_done) begin
                    $error("packet_done: expected %0d, actual %0d",
                           want.packet_done, o_out.packet_done);
                    mismatches++;
                end
                if (o_out.moved !== want.moved) begin
                    $error("moved: expected %0d, actual %0d", want.moved, o_out.moved);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = REG_X_LIMIT;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_framing();
        test_limits();
        test_backpressure();
        test_random_walk(X_LIMIT_RESET, Y_LIMIT_RESET, 1'b0, 85);
        test_random_walk('1, '1, 1'b1, 85);
        test_random_walk('0, '0, 1'b0, 70);
        test_random_walk('1, '1, 1'b0, 85);
        test_random_walk(10'd1, 10'd1022, 1'b0, 85);
        test_random_walk(10'($urandom()), 10'($urandom()), 1'b0, 85);
        wait_for_reports();

        $display("Covered %0d mouse bytes and %0d ignored bytes under %0d limit settings.",
                 n_mouse, n_ignored, n_settings);
        $display("%0d packets completed, %0d of them with movement.", n_packets, n_moved);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pmt_pkg.sv
hw/rtl/pmt_front.sv
hw/rtl/pmt_queue.sv
hw/rtl/pmt_back.sv
hw/rtl/ps2_mouse_packet_tracker.sv
hw/rtl/pmt_checker.sv
verif/tb.sv
